FILE: sv/assert_macros.svh
// Assertion macros for the supervisor top level; clocked on clk, HJMS_ASSERT is disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define HJMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define HJMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HJMS_ASSERT(lbl, prop, msg)
`define HJMS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: sv/hjms_pkg.sv
// Types and constants for the homing, jog and run supervisor.
package hjms_pkg;

  // Supervisor phase.
  typedef enum logic [1:0] {
    PH_SEEK    = 2'd0,
    PH_BACKOFF = 2'd1,
    PH_RUN     = 2'd2
  } phase_t;

  // Motor status codes reported by the drive.
  localparam logic [2:0] MS_STOPPED  = 3'd0;
  localparam logic [2:0] MS_STARTING = 3'd1;
  localparam logic [2:0] MS_RUNNING  = 3'd2;
  localparam logic [2:0] MS_STOPPING = 3'd3;
  localparam logic [2:0] MS_FAULT    = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_VELOCITY_MIN     = 2'd0;
  localparam logic [1:0] REG_VELOCITY_MAX     = 2'd1;
  localparam logic [1:0] REG_RELEASE_DURATION = 2'd2;
  localparam logic [1:0] REG_UI_ENABLED       = 2'd3;

  localparam int CfgDataW = 16;

  typedef struct packed {
    logic [14:0] velocity_min;
    logic [14:0] velocity_max;
    logic [15:0] release_duration;
    logic        ui_enabled;
  } cfg_t;

  typedef struct packed {
    logic        at_home;
    logic [15:0] pot_value;
    logic        button_fwd;
    logic        button_rev;
    logic [2:0]  motor_status;
    logic [15:0] fault_bits;
    logic [31:0] now_tick;
  } item_t;

  typedef struct packed {
    logic signed [15:0] velocity_cmd;
    logic               start_req;
    logic               stop_req;
    logic               clear_req;
    logic [15:0]        clear_mask;
    logic [1:0]         phase_out;
  } result_t;

endpackage

FILE: sv/hjms_cfg_regs.sv
// Configuration register bank of the supervisor.
module hjms_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_idx,
  input  logic [hjms_pkg::CfgDataW-1:0]     cfg_data,
  output hjms_pkg::cfg_t                    cfg
);
  import hjms_pkg::*;

  // Registers take their documented reset values and are written one at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.velocity_min     <= 15'd0;
      cfg.velocity_max     <= 15'd32767;
      cfg.release_duration <= 16'd500;
      cfg.ui_enabled       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_VELOCITY_MIN:     cfg.velocity_min     <= cfg_data[14:0];
        REG_VELOCITY_MAX:     cfg.velocity_max     <= cfg_data[14:0];
        REG_RELEASE_DURATION: cfg.release_duration <= cfg_data[15:0];
        REG_UI_ENABLED:       cfg.ui_enabled       <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/hjms_step.sv
// Per-tick supervisor logic: phase, direction and held command state plus result decode.
module hjms_step #(
  parameter int TICK_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  hjms_pkg::item_t   item,
  input  hjms_pkg::cfg_t    cfg,
  output hjms_pkg::result_t result
);
  import hjms_pkg::*;

  localparam int CmpW = (TICK_BITS > 16) ? TICK_BITS : 16;

  phase_t                 phase, phase_next;
  logic [TICK_BITS-1:0]   release_start, release_start_next;
  logic                   dir_negative, dir_negative_next;
  logic [15:0]            held_cmd, held_cmd_next;

  logic [TICK_BITS-1:0]   now_t;
  logic [TICK_BITS-1:0]   elapsed;
  logic signed [16:0]     pot_s;
  logic signed [15:0]     range_s;
  logic signed [32:0]     prod;
  logic [15:0]            speed;
  logic [15:0]            run_cmd;
  logic                   start_req, stop_req, clear_req;

  // Tick arithmetic is modulo 2^TICK_BITS.
  assign now_t   = TICK_BITS'(item.now_tick);
  assign elapsed = now_t - release_start;

  // Run speed: floor(pot * (max - min) / 65536) + min, signed by the stored direction.
  assign pot_s   = $signed({1'b0, item.pot_value});
  assign range_s = $signed({1'b0, cfg.velocity_max}) - $signed({1'b0, cfg.velocity_min});
  assign prod    = pot_s * range_s;
  assign speed   = prod[31:16] + {1'b0, cfg.velocity_min};
  assign run_cmd = dir_negative ? (16'd0 - speed) : speed;

  // Next state and requests for the tick being handled.
  always_comb begin
    phase_next         = phase;
    release_start_next = release_start;
    dir_negative_next  = dir_negative;
    held_cmd_next      = held_cmd;
    start_req          = 1'b0;
    stop_req           = 1'b0;
    clear_req          = 1'b0;
    case (phase)
      PH_SEEK: begin
        held_cmd_next     = 16'd0 - {1'b0, cfg.velocity_min};
        dir_negative_next = 1'b1;
        if (item.at_home) begin
          phase_next         = PH_BACKOFF;
          release_start_next = now_t;
        end
      end
      PH_BACKOFF: begin
        held_cmd_next     = {1'b0, cfg.velocity_min};
        dir_negative_next = 1'b0;
        if (CmpW'(elapsed) >= CmpW'(cfg.release_duration)) begin
          phase_next = PH_RUN;
        end
      end
      default: begin
        if (cfg.ui_enabled) begin
          held_cmd_next = run_cmd;
          if (item.button_fwd != item.button_rev) begin
            // One button held: pick direction, start or clear a fault.
            dir_negative_next = item.button_rev;
            if (item.motor_status == MS_STOPPED || item.motor_status == MS_STOPPING) begin
              start_req = 1'b1;
            end else if (item.motor_status == MS_FAULT) begin
              clear_req = 1'b1;
            end
          end else if (!item.button_fwd) begin
            // No button held: stop a moving motor or clear a fault.
            if (item.motor_status == MS_STARTING || item.motor_status == MS_RUNNING) begin
              stop_req = 1'b1;
            end else if (item.motor_status == MS_FAULT) begin
              clear_req = 1'b1;
            end
          end
        end
      end
    endcase
  end

  // Result of this tick; the phase is the one it was handled in.
  always_comb begin
    result.velocity_cmd = $signed(held_cmd_next);
    result.start_req    = start_req;
    result.stop_req     = stop_req;
    result.clear_req    = clear_req;
    result.clear_mask   = clear_req ? item.fault_bits : 16'd0;
    result.phase_out    = phase;
  end

  // State advances once per handled tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SEEK;
      release_start <= '0;
      dir_negative  <= 1'b0;
      held_cmd      <= 16'd0;
    end else if (advance) begin
      phase         <= phase_next;
      release_start <= release_start_next;
      dir_negative  <= dir_negative_next;
      held_cmd      <= held_cmd_next;
    end
  end

endmodule

FILE: sv/homing_jog_motor_supervisor.sv
// Top level: homing, jog and run supervisor with registered request and result stages.
// An accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle unless stalled; a single pass with one 17x16 multiply.
// Back-pressure on the result side holds the input register, which stalls in_ready.
// Reset (rst, synchronous): phase seek, direction forward, held command 0,
// registers at their defaults, both stages empty.
`include "assert_macros.svh"
module homing_jog_motor_supervisor #(
  parameter int TICK_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [hjms_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          at_home,
  input  logic [15:0]                   pot_value,
  input  logic                          button_fwd,
  input  logic                          button_rev,
  input  logic [2:0]                    motor_status,
  input  logic [15:0]                   fault_bits,
  input  logic [31:0]                   now_tick,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            velocity_cmd,
  output logic                          start_req,
  output logic                          stop_req,
  output logic                          clear_req,
  output logic [15:0]                   clear_mask,
  output logic [1:0]                    phase_out
);
  import hjms_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_q_valid;
  logic    advance;
  result_t step_res;
  result_t res_q;

  hjms_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // The input register moves into the result register when that one is free or being taken.
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= '{at_home:      at_home,
                pot_value:    pot_value,
                button_fwd:   button_fwd,
                button_rev:   button_rev,
                motor_status: motor_status,
                fault_bits:   fault_bits,
                now_tick:     now_tick};
    end
  end

  hjms_step #(
    .TICK_BITS (TICK_BITS)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_q),
    .cfg     (cfg),
    .result  (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign velocity_cmd = res_q.velocity_cmd;
  assign start_req    = res_q.start_req;
  assign stop_req     = res_q.stop_req;
  assign clear_req    = res_q.clear_req;
  assign clear_mask   = res_q.clear_mask;
  assign phase_out    = res_q.phase_out;

  // Checks on the supervisor's own logic.
  `HJMS_ASSERT(a_one_request, out_valid |-> $onehot0({start_req, stop_req, clear_req}), "more than one motor request in a tick")
  `HJMS_ASSERT(a_req_only_run, out_valid && (start_req || stop_req || clear_req) |-> phase_out == PH_RUN, "motor request outside run phase")
  `HJMS_ASSERT(a_mask_zero, out_valid && !clear_req |-> clear_mask == 16'd0, "clear mask set without clear request")
  `HJMS_ASSERT(a_hold_input, in_q_valid && out_valid && !out_ready |=> in_q_valid, "input register dropped while stalled")
  `HJMS_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && !in_q_valid, "pipeline not empty after reset")

endmodule

FILE: verif/homing_jog_motor_supervisor_tb.sv
// Self-checking testbench for the homing, jog and run supervisor: directed script, then random ticks.
module homing_jog_motor_supervisor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hjms_pkg::*;

  localparam int CLK_HALF          = 5;
  localparam int RESET_CYCLES      = 8;
  localparam int N_SCRIPT          = 26;
  localparam int N_SETTINGS        = 8;
  localparam int TICKS_PER_SETTING = 75;
  localparam int UI_OFF_SETTING    = 3;
  localparam int PRESSURE_SETTING  = 5;
  localparam int HOLD_OFF_CYCLES   = 300;
  localparam int DRAIN_CYCLES      = 4;
  localparam int WATCHDOG_LIMIT    = 2000;

  // Motor status codes that the package does not name.
  localparam logic [2:0] MS_DIAGNOSTIC = 3'd5;
  localparam logic [2:0] MS_UNDEFINED  = 3'd7;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;
  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // One line of the directed script: a register write or a tick request.
  typedef struct {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    item_t       req;
    bit          given;
    result_t     want;
  } script_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               at_home;
  logic [15:0]        pot_value;
  logic               button_fwd;
  logic               button_rev;
  logic [2:0]         motor_status;
  logic [15:0]        fault_bits;
  logic [31:0]        now_tick;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] velocity_cmd;
  logic               start_req;
  logic               stop_req;
  logic               clear_req;
  logic [15:0]        clear_mask;
  logic [1:0]         phase_out;

  // Predicted supervisor state and register copy.
  phase_t      sup_phase;
  logic [31:0] home_tick;
  logic        heading_rev;
  logic [15:0] last_cmd;
  cfg_t        sup_cfg;

  result_t     pending_results[$];
  script_row_t script[N_SCRIPT];

  int  error_count;
  int  ticks_sent;
  int  results_checked;
  int  reg_writes;
  int  long_stalls;
  int  burst_left;
  bit  steady_send;
  bit  hold_off_pending;

  homing_jog_motor_supervisor uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .at_home(at_home), .pot_value(pot_value), .button_fwd(button_fwd),
    .button_rev(button_rev), .motor_status(motor_status), .fault_bits(fault_bits),
    .now_tick(now_tick),
    .out_valid(out_valid), .out_ready(out_ready),
    .velocity_cmd(velocity_cmd), .start_req(start_req), .stop_req(stop_req),
    .clear_req(clear_req), .clear_mask(clear_mask), .phase_out(phase_out)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  function automatic item_t tick_of(logic home, logic [15:0] pot, logic fwd, logic rev,
                                    logic [2:0] status, logic [15:0] faults,
                                    logic [31:0] now);
    item_t it;
    it.at_home      = home;
    it.pot_value    = pot;
    it.button_fwd   = fwd;
    it.button_rev   = rev;
    it.motor_status = status;
    it.fault_bits   = faults;
    it.now_tick     = now;
    return it;
  endfunction

  function automatic result_t outcome(logic signed [15:0] cmd, logic start, logic stop,
                                      logic clear, logic [15:0] mask, phase_t ph);
    result_t r;
    r.velocity_cmd = cmd;
    r.start_req    = start;
    r.stop_req     = stop;
    r.clear_req    = clear;
    r.clear_mask   = mask;
    r.phase_out    = ph;
    return r;
  endfunction

  // Advance the predicted supervisor by one tick and return what it should report.
  function automatic result_t supervise_tick(item_t it);
    result_t     r;
    int          span;
    longint      scaled;
    logic [15:0] speed;
    logic [31:0] elapsed;
    r = '0;
    r.phase_out = sup_phase;
    case (sup_phase)
      PH_SEEK: begin
        last_cmd    = 16'd0 - {1'b0, sup_cfg.velocity_min};
        heading_rev = 1'b1;
        if (it.at_home) begin
          sup_phase = PH_BACKOFF;
          home_tick = it.now_tick;
        end
      end
      PH_BACKOFF: begin
        last_cmd    = {1'b0, sup_cfg.velocity_min};
        heading_rev = 1'b0;
        // The tick counter wraps, so the elapsed time is taken modulo 2^32.
        elapsed = it.now_tick - home_tick;
        if (elapsed >= {16'd0, sup_cfg.release_duration}) sup_phase = PH_RUN;
      end
      default: begin
        if (sup_cfg.ui_enabled) begin
          // The span may be negative when min exceeds max; the shift floors.
          span   = int'({1'b0, sup_cfg.velocity_max}) - int'({1'b0, sup_cfg.velocity_min});
          scaled = longint'(it.pot_value) * span;
          speed  = 16'((scaled >>> 16) + longint'({1'b0, sup_cfg.velocity_min}));
          if (heading_rev) speed = 16'd0 - speed;
          last_cmd = speed;
          // Direction changes only after the speed has been worked out.
          if (it.button_fwd != it.button_rev) begin
            heading_rev = it.button_rev;
            if (it.motor_status == MS_STOPPED || it.motor_status == MS_STOPPING)
              r.start_req = 1'b1;
            else if (it.motor_status == MS_FAULT)
              r.clear_req = 1'b1;
          end else if (!it.button_fwd) begin
            if (it.motor_status == MS_STARTING || it.motor_status == MS_RUNNING)
              r.stop_req = 1'b1;
            else if (it.motor_status == MS_FAULT)
              r.clear_req = 1'b1;
          end
        end
      end
    endcase
    r.velocity_cmd = last_cmd;
    r.clear_mask   = r.clear_req ? it.fault_bits : 16'd0;
    return r;
  endfunction

  function automatic item_t random_tick();
    item_t it;
    it.at_home    = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 5) == 0)
      it.pot_value = 16'h0000;
    else if ($urandom_range(0, 4) == 0)
      it.pot_value = 16'hFFFF;
    else
      it.pot_value = 16'($urandom);
    it.button_fwd = 1'($urandom_range(0, 1));
    it.button_rev = 1'($urandom_range(0, 1));
    // Mostly real drive states, now and then diagnostic or an unused code.
    if ($urandom_range(0, 7) == 0)
      it.motor_status = 3'($urandom_range(MS_DIAGNOSTIC, MS_UNDEFINED));
    else
      it.motor_status = 3'($urandom_range(MS_STOPPED, MS_FAULT));
    it.fault_bits = 16'($urandom);
    it.now_tick   = $urandom;
    return it;
  endfunction

  // Write one register once every outstanding result has come back.
  task automatic write_register(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_VELOCITY_MIN:     sup_cfg.velocity_min     = val[14:0];
      REG_VELOCITY_MAX:     sup_cfg.velocity_max     = val[14:0];
      REG_RELEASE_DURATION: sup_cfg.release_duration = val;
      REG_UI_ENABLED:       sup_cfg.ui_enabled       = val[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Offer one tick request, pacing the sender in bursts with random gaps.
  task automatic send_request(item_t it, bit given, result_t want);
    int      gap;
    result_t predicted;
    if (!steady_send && burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    at_home      <= it.at_home;
    pot_value    <= it.pot_value;
    button_fwd   <= it.button_fwd;
    button_rev   <= it.button_rev;
    motor_status <= it.motor_status;
    fault_bits   <= it.fault_bits;
    now_tick     <= it.now_tick;
    do @(posedge clk); while (!in_ready);
    predicted = supervise_tick(it);
    pending_results.push_back(given ? want : predicted);
    ticks_sent++;
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("velocity_cmd", longint'(want.velocity_cmd), longint'(velocity_cmd));
        check_field("start_req", want.start_req, start_req);
        check_field("stop_req", want.stop_req, stop_req);
        check_field("clear_req", want.clear_req, clear_req);
        check_field("clear_mask", want.clear_mask, clear_mask);
        check_field("phase_out", want.phase_out, phase_out);
        results_checked++;
      end
    end
  end

  // Result side: stall modes of its own, plus one long hold-off on request.
  initial begin : result_drain
    rx_mode_t   mode;
    int         mode_left;
    logic [7:0] mask;
    out_ready = 1'b0;
    mode      = RX_OPEN;
    mode_left = 0;
    mask      = 8'hFF;
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_pending = 1'b0;
        long_stalls++;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 96);
        mask      = 8'($urandom);
      end
      mode_left--;
      case (mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ready <= mask[0];
          mask = {mask[0], mask[7:1]};
        end
      endcase
    end
  end

  // Give up when no request moves on either side for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Timed out after %0d cycles without a handshake.", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic [14:0] vmin;
    logic [14:0] vmax;
    logic [15:0] hold_time;
    logic        ui_on;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_idx      = REG_VELOCITY_MIN;
    cfg_data     = '0;
    in_valid     = 1'b0;
    at_home      = 1'b0;
    pot_value    = '0;
    button_fwd   = 1'b0;
    button_rev   = 1'b0;
    motor_status = MS_STOPPED;
    fault_bits   = '0;
    now_tick     = '0;
    error_count      = 0;
    ticks_sent       = 0;
    results_checked  = 0;
    reg_writes       = 0;
    long_stalls      = 0;
    burst_left       = 0;
    steady_send      = 1'b0;
    hold_off_pending = 1'b0;

    // Power-on state: seeking home, forward, registers at their defaults.
    sup_phase   = PH_SEEK;
    home_tick   = '0;
    heading_rev = 1'b0;
    last_cmd    = '0;
    sup_cfg     = '{velocity_min: 15'd0, velocity_max: 15'd32767,
                    release_duration: 16'd500, ui_enabled: 1'b1};

    // Homing with a tick wrap, a mid-back-off duration change, then every button case.
    script = '{
      '{ROW_TICK, '0, '0, tick_of(1'b0, 16'h1234, 1'b1, 1'b0, MS_FAULT, 16'hFFFF, 32'd0),
        1'b1, outcome(16'sd0, 1'b0, 1'b0, 1'b0, 16'h0, PH_SEEK)},
      '{ROW_WRITE, REG_VELOCITY_MIN, 16'd32767, '0, 1'b0, '0},
      '{ROW_TICK, '0, '0, tick_of(1'b0, 16'hFFFF, 1'b1, 1'b1, MS_STOPPED, 16'h0, 32'd100),
        1'b1, outcome(-16'sd32767, 1'b0, 1'b0, 1'b0, 16'h0, PH_SEEK)},
      '{ROW_WRITE, REG_VELOCITY_MIN, 16'd1000, '0, 1'b0, '0},
      '{ROW_WRITE, REG_RELEASE_DURATION, 16'd5, '0, 1'b0, '0},
      '{ROW_TICK, '0, '0, tick_of(1'b1, 16'h0, 1'b0, 1'b1, MS_RUNNING, 16'h0, 32'hFFFF_FFFE),
        1'b1, outcome(-16'sd1000, 1'b0, 1'b0, 1'b0, 16'h0, PH_SEEK)},
      '{ROW_TICK, '0, '0, tick_of(1'b0, 16'h0, 1'b1, 1'b0, MS_FAULT, 16'hFFFF, 32'hFFFF_FFFF),
        1'b1, outcome(16'sd1000, 1'b0, 1'b0, 1'b0, 16'h0, PH_BACKOFF)},
      '{ROW_WRITE, REG_RELEASE_DURATION, 16'd65535, '0, 1'b0, '0},
      '{ROW_TICK, '0, '0, tick_of(1'b1, 16'h0, 1'b0, 1'b0, MS_RUNNING, 16'h0, 32'd2),
        1'b1, outcome(16'sd1000, 1'b0, 1'b0, 1'b0, 16'h0, PH_BACKOFF)},
      '{ROW_WRITE, REG_RELEASE_DURATION, 16'd5, '0, 1'b0, '0},
      '{ROW_TICK, '0, '0, tick_of(1'b0, 16'h0, 1'b0, 1'b0, MS_STOPPED, 16'h0, 32'd3),
        1'b1, outcome(16'sd1000, 1'b0, 1'b0, 1'b0, 16'h0, PH_BACKOFF)},
      '{ROW_TICK, '0, '0, tick_of(1'b0, 16'h0, 1'b0, 1'b0, MS_RUNNING, 16'h0, 32'd4),
        1'b1, outcome(16'sd1000, 1'b0, 1'b1, 1'b0, 16'h0, PH_RUN)},
      '{ROW_TICK, '0, '0, tick_of(1'b0, 16'hFFFF, 1'b1, 1'b0, MS_STOPPED, 16'h0, 32'd5),
        1'b0, '0},
      '{ROW_TICK, '0, '0, tick_of(1'b0, 16'h8000, 1'b0, 1'b1, MS_FAULT, 16'hFFFF, 32'd6),
        1'b0, '0},
      '{ROW_TICK, '0, '0, tick_of(1'b0, 16'h0, 1'b0, 1'b1, MS_STOPPING, 16'h0, 32'd7),
        1'b1, outcome(-16'sd1000, 1'b1, 1'b0, 1'b0, 16'h0, PH_RUN)},
      '{ROW_TICK, '0, '0, tick_of(1'b0, 16'h1234, 1'b1, 1'b1, MS_STOPPED, 16'h0, 32'd8),
        1'b0, '0},
      '{ROW_TICK, '0, '0, tick_of(1'b0, 16'h4321, 1'b0, 1'b0, MS_FAULT, 16'hA5A5, 32'd9),
        1'b0, '0},
      '{ROW_TICK, '0, '0, tick_of(1'b1, 16'hFFFF, 1'b0, 1'b0, MS_DIAGNOSTIC, 16'hFFFF, 32'd10),
        1'b0, '0},
      '{ROW_TICK, '0, '0, tick_of(1'b0, 16'h7777, 1'b0, 1'b0, MS_UNDEFINED, 16'hFFFF, 32'd11),
        1'b0, '0},
      '{ROW_TICK, '0, '0, tick_of(1'b0, 16'h2222, 1'b1, 1'b0, MS_STARTING, 16'h0, 32'd12),
        1'b0, '0},
      '{ROW_WRITE, REG_VELOCITY_MAX, 16'd0, '0, 1'b0, '0},
      '{ROW_TICK, '0, '0, tick_of(1'b0, 16'hFFFF, 1'b1, 1'b0, MS_STOPPED, 16'h0, 32'd13),
        1'b0, '0},
      '{ROW_TICK, '0, '0, tick_of(1'b0, 16'h0001, 1'b0, 1'b1, MS_STOPPING, 16'h0, 32'd14),
        1'b0, '0},
      '{ROW_WRITE, REG_UI_ENABLED, 16'd0, '0, 1'b0, '0},
      '{ROW_TICK, '0, '0, tick_of(1'b0, 16'hFFFF, 1'b0, 1'b1, MS_FAULT, 16'hFFFF, 32'd15),
        1'b0, '0},
      '{ROW_WRITE, REG_UI_ENABLED, 16'd1, '0, 1'b0, '0}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed script.
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE)
        write_register(script[i].reg_idx, script[i].reg_val);
      else
        send_request(script[i].req, script[i].given, script[i].want);
    end

    // Random run-phase ticks under a series of register settings.
    for (int s = 0; s < N_SETTINGS; s++) begin
      vmin      = 15'($urandom_range(0, 32767));
      vmax      = 15'($urandom_range(0, 32767));
      hold_time = 16'($urandom);
      ui_on     = (s != UI_OFF_SETTING);
      case (s)
        0: begin
          vmin      = 15'd0;
          vmax      = 15'd32767;
          hold_time = 16'd0;
        end
        1: begin
          vmin      = 15'd32767;
          vmax      = 15'd0;
          hold_time = 16'd65535;
        end
        2: begin
          vmin = 15'd32767;
          vmax = 15'd32767;
        end
        default: ;
      endcase
      write_register(REG_VELOCITY_MIN, {1'b0, vmin});
      write_register(REG_VELOCITY_MAX, {1'b0, vmax});
      write_register(REG_RELEASE_DURATION, hold_time);
      write_register(REG_UI_ENABLED, {15'd0, ui_on});
      // Back the result side up while requests keep coming, so the input stalls.
      if (s == PRESSURE_SETTING) begin
        hold_off_pending = 1'b1;
        steady_send      = 1'b1;
      end
      for (int n = 0; n < TICKS_PER_SETTING; n++) send_request(random_tick(), 1'b0, '0);
      steady_send = 1'b0;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d ticks (homing, back-off and run) with %0d register writes.",
             ticks_sent, reg_writes);
    $display("Checked %0d results; %0d long result-side stall(s), %0d mismatch(es).",
             results_checked, long_stalls, error_count);
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
